// ===== rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared widths, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // Field widths of the request and result.
    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // The usage map is stored as bytes of slot bits.
    localparam int WORD_W = 8;
    localparam int BIT_W  = 3;

    // Slot count after reset.
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } bsa_state_t;

endpackage

// ===== rtl/bsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/bitmap_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// First-free slot allocator over a byte-wide usage bitmap held in a RAM.
// ----------------------------------------------------------------------------
// After reset the block clears the usage map, one byte per cycle, and
// holds s_axis_tready low meanwhile. A request is then handled one at a
// time by a small sequencer around one byte-wide first-zero finder and the
// map RAM: the request is taken, then the map bytes are examined one by
// one. Free and query read one byte; an allocate scans bytes from slot 0
// upward up to and including the first one with a free slot below the
// limit (at most ceil(limit/8) bytes). A full allocator answers after the
// first byte. The result sits in an output register, and a new request is
// taken while it waits; the block stalls only if a second result is ready
// before the first one is taken. The limit is min(slot_count, NUM_SLOTS).
module bitmap_slot_allocator_unit #(
    parameter int NUM_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] slot_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] result_slot, [8] in_use,
                                        // [17:9] used_total, [23:18] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status

    // Slot count register.
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    localparam int DEPTH = NUM_SLOTS / bsa_pkg::WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AW + bsa_pkg::BIT_W + 1 > bsa_pkg::COUNT_W + 1)
                           ? AW + bsa_pkg::BIT_W + 1 : bsa_pkg::COUNT_W + 1;

    // Lowest clear bit of a map byte.
    function automatic logic [bsa_pkg::BIT_W:0] first_zero(
        input logic [bsa_pkg::WORD_W-1:0] w
    );
        logic [bsa_pkg::BIT_W:0] r;
        r = '0;
        for (int i = bsa_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = {1'b1, bsa_pkg::BIT_W'(i)};
            end
        end
        return r;
    endfunction

    bsa_pkg::bsa_state_t state_reg, state_next;

    logic [AW-1:0]                   clr_ptr_reg, clr_ptr_next;
    logic [AW-1:0]                   ptr_reg, ptr_next;
    logic [bsa_pkg::REQ_W-1:0]       req_reg, req_next;
    logic [bsa_pkg::SLOT_W-1:0]      idx_reg, idx_next;
    logic [bsa_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [bsa_pkg::COUNT_W-1:0]     slot_count_reg, slot_count_next;

    logic                            out_valid_reg, out_valid_next;
    logic [bsa_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [bsa_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic                            out_in_use_reg, out_in_use_next;
    logic [bsa_pkg::COUNT_W-1:0]     out_total_reg, out_total_next;

    logic                            ram_wr_en;
    logic [AW-1:0]                   ram_wr_addr;
    logic [bsa_pkg::WORD_W-1:0]      ram_wr_data;
    logic [bsa_pkg::WORD_W-1:0]      ram_rd_data;

    logic                            req_fire;
    logic                            out_free;
    logic                            clr_done;
    logic [CW-1:0]                   lim;
    logic [CW-1:0]                   idx_cw;
    logic [CW-1:0]                   cand_cw;
    logic [CW-1:0]                   next_base_cw;
    logic [bsa_pkg::BIT_W:0]         fz;
    logic [bsa_pkg::WORD_W-1:0]      bit_mask;
    logic                            idx_bit;

    // Decisions of the check step.
    logic                            chk_finish;
    logic                            chk_advance;
    logic                            chk_write;
    logic [bsa_pkg::WORD_W-1:0]      chk_word;
    logic [bsa_pkg::STATUS_W-1:0]    chk_status;
    logic [bsa_pkg::SLOT_W-1:0]      chk_slot;
    logic                            chk_in_use;
    logic [bsa_pkg::COUNT_W-1:0]     chk_cnt;

    // Usage map storage.
    bsa_ram #(
        .WIDTH  (bsa_pkg::WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ptr_next),
        .rd_data (ram_rd_data)
    );

    // Handshake terms and the usable limit.
    assign s_axis_tready = (state_reg == bsa_pkg::S_IDLE);
    assign req_fire      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign clr_done      = (clr_ptr_reg == AW'(DEPTH - 1));

    assign lim = (CW'(slot_count_reg) > CW'(NUM_SLOTS)) ? CW'(NUM_SLOTS)
                                                         : CW'(slot_count_reg);

    // Shared byte examination: first free bit and the selected bit.
    assign fz           = first_zero(ram_rd_data);
    assign idx_cw       = CW'(idx_reg);
    assign cand_cw      = CW'({ptr_reg, fz[bsa_pkg::BIT_W-1:0]});
    assign next_base_cw = CW'({ptr_reg, bsa_pkg::BIT_W'(0)}) + CW'(bsa_pkg::WORD_W);
    assign bit_mask     = bsa_pkg::WORD_W'(1) << idx_reg[bsa_pkg::BIT_W-1:0];
    assign idx_bit      = ram_rd_data[idx_reg[bsa_pkg::BIT_W-1:0]];

    // Check step: decide the outcome for the byte now on the read port.
    always_comb
    begin
        chk_finish  = 1'b1;
        chk_advance = 1'b0;
        chk_write   = 1'b0;
        chk_word    = ram_rd_data;
        chk_status  = bsa_pkg::ST_OK;
        chk_slot    = '0;
        chk_in_use  = 1'b0;
        chk_cnt     = cnt_reg;
        case (req_reg)
            bsa_pkg::REQ_ALLOC:
            begin
                if (CW'(cnt_reg) >= lim)
                begin
                    chk_status = bsa_pkg::ST_FULL;
                end
                else if (fz[bsa_pkg::BIT_W] && (cand_cw < lim))
                begin
                    chk_write = 1'b1;
                    chk_word  = ram_rd_data
                                | (bsa_pkg::WORD_W'(1) << fz[bsa_pkg::BIT_W-1:0]);
                    chk_slot  = cand_cw[bsa_pkg::SLOT_W-1:0];
                    chk_cnt   = cnt_reg + bsa_pkg::COUNT_W'(1);
                end
                else if (next_base_cw >= lim)
                begin
                    chk_status = bsa_pkg::ST_FULL;
                end
                else
                begin
                    chk_finish  = 1'b0;
                    chk_advance = 1'b1;
                end
            end
            bsa_pkg::REQ_FREE:
            begin
                if (idx_cw >= lim)
                begin
                    chk_status = bsa_pkg::ST_RANGE;
                end
                else if (!idx_bit)
                begin
                    chk_status = bsa_pkg::ST_NOT_USED;
                end
                else
                begin
                    chk_write = 1'b1;
                    chk_word  = ram_rd_data & ~bit_mask;
                    if (cnt_reg != '0)
                    begin
                        chk_cnt = cnt_reg - bsa_pkg::COUNT_W'(1);
                    end
                end
            end
            bsa_pkg::REQ_QUERY:
            begin
                if (idx_cw >= lim)
                begin
                    chk_status = bsa_pkg::ST_RANGE;
                end
                else
                begin
                    chk_in_use = idx_bit;
                end
            end
            default:
            begin
                // Unused request kind: plain ok result, no change.
                chk_status = bsa_pkg::ST_OK;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsa_pkg::S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = bsa_pkg::S_IDLE;
                end
            end
            bsa_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = bsa_pkg::S_CHECK;
                end
            end
            bsa_pkg::S_CHECK:
            begin
                if (chk_finish && out_free)
                begin
                    state_next = bsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bsa_pkg::S_CLEAR;
            end
        endcase
    end

    // Datapath, map writes and the result register.
    always_comb
    begin
        clr_ptr_next    = clr_ptr_reg;
        ptr_next        = ptr_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        slot_count_next = cfg_wr_en ? cfg_wr_data : slot_count_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_in_use_next = out_in_use_reg;
        out_total_next  = out_total_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = ptr_reg;
        ram_wr_data     = chk_word;
        case (state_reg)
            bsa_pkg::S_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_ptr_reg;
                ram_wr_data  = '0;
                clr_ptr_next = clr_ptr_reg + AW'(1);
            end
            bsa_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    req_next = s_axis_tuser;
                    idx_next = s_axis_tdata;
                    if (s_axis_tuser == bsa_pkg::REQ_ALLOC)
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        ptr_next = AW'(s_axis_tdata[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W]);
                    end
                end
            end
            bsa_pkg::S_CHECK:
            begin
                if (chk_advance)
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
                else if (chk_finish && out_free)
                begin
                    ram_wr_en       = chk_write;
                    cnt_next        = chk_cnt;
                    out_valid_next  = 1'b1;
                    out_status_next = chk_status;
                    out_slot_next   = chk_slot;
                    out_in_use_next = chk_in_use;
                    out_total_next  = chk_cnt;
                end
            end
            default:
            begin
                clr_ptr_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bsa_pkg::S_CLEAR;
            clr_ptr_reg    <= '0;
            cnt_reg        <= '0;
            slot_count_reg <= bsa_pkg::SLOT_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            cnt_reg        <= cnt_next;
            slot_count_reg <= slot_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_in_use_reg <= out_in_use_next;
        out_total_reg  <= out_total_next;
    end

    // Result stream outputs.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_total_reg, out_in_use_reg, out_slot_reg};

endmodule

// ===== tb/sv/slot_result_checker.sv =====
// ----------------------------------------------------------------------------
// Slot allocator result checker
// Watches the request, result and slot count ports of the allocator. It keeps
// its own usage bitmap and used-slot count, works out the answer to every
// accepted request, and compares each accepted result with the oldest answer
// still owed.
// ----------------------------------------------------------------------------
module slot_result_checker
    import bsa_pkg::*;
#(
    parameter int NUM_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    // Request stream, observed only.
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] slot_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type

    // Result stream, observed only.
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] result_slot, [8] in_use,
                                        // [17:9] used_total, [23:18] zero
    input  logic [1:0]  m_axis_tuser,   // [1:0] status

    // Slot count register writes.
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,

    // Number of results still owed, and mismatches seen so far.
    output int          answers_owed,
    output int          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One answer of the allocator.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                in_use;
        logic [COUNT_W-1:0]  used_total;
    } slot_answer_t;

    // Shadow state of the allocator.
    logic [NUM_SLOTS-1:0] usage_bits;
    logic [COUNT_W-1:0]   used_slots;
    logic [COUNT_W-1:0]   slot_count;

    slot_answer_t awaited_answers[$];
    int           error_tally;

    // Apply one request to the shadow state and return the answer it earns.
    function automatic slot_answer_t serve_request(input logic [REQ_W-1:0]  kind,
                                                   input logic [SLOT_W-1:0] idx);
        slot_answer_t ans;
        int           limit;
        int           pick;
        limit          = (slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count);
        pick           = -1;
        ans.status     = ST_OK;
        ans.slot       = '0;
        ans.in_use     = 1'b0;
        case (kind)
            REQ_ALLOC:
            begin
                // Lowest free slot below the limit, unless the count says full.
                if (used_slots < limit)
                begin
                    for (int i = limit - 1; i >= 0; i--)
                    begin
                        if (!usage_bits[i])
                            pick = i;
                    end
                end
                if (pick < 0)
                    ans.status = ST_FULL;
                else
                begin
                    usage_bits[pick] = 1'b1;
                    used_slots       = used_slots + 1'b1;
                    ans.slot         = SLOT_W'(pick);
                end
            end
            REQ_FREE:
            begin
                if (idx >= limit)
                    ans.status = ST_RANGE;
                else if (!usage_bits[idx])
                    ans.status = ST_NOT_USED;
                else
                begin
                    usage_bits[idx] = 1'b0;
                    if (used_slots != 0)
                        used_slots = used_slots - 1'b1;
                end
            end
            REQ_QUERY:
            begin
                if (idx >= limit)
                    ans.status = ST_RANGE;
                else
                    ans.in_use = usage_bits[idx];
            end
            default:
            begin
                // The unused request kind leaves everything as it is.
            end
        endcase
        ans.used_total = used_slots;
        return ans;
    endfunction

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        error_tally++;
        $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    // Track writes, predict on requests, and compare on results.
    always @(posedge clk or negedge rst_n)
    begin
        slot_answer_t want;
        if (!rst_n)
        begin
            usage_bits  = '0;
            used_slots  = '0;
            slot_count  = SLOT_COUNT_RESET;
            awaited_answers.delete();
            error_tally = 0;
        end
        else
        begin
            if (cfg_wr_en)
                slot_count = cfg_wr_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_answers.size() == 0)
                    report_mismatch("result with no request open, used_total",
                                    m_axis_tdata[17:9], 0);
                else
                begin
                    want = awaited_answers.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[7:0] !== want.slot)
                        report_mismatch("result_slot", m_axis_tdata[7:0], want.slot);
                    if (m_axis_tdata[8] !== want.in_use)
                        report_mismatch("in_use", m_axis_tdata[8], want.in_use);
                    if (m_axis_tdata[17:9] !== want.used_total)
                        report_mismatch("used_total", m_axis_tdata[17:9],
                                        want.used_total);
                    if (m_axis_tdata[23:18] !== 6'd0)
                        report_mismatch("padding bits", m_axis_tdata[23:18], 0);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                awaited_answers.push_back(serve_request(s_axis_tuser, s_axis_tdata));
        end
        answers_owed   <= awaited_answers.size();
        mismatch_count <= error_tally;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate, free, query and unused requests into the allocator under
// a series of slot counts, with random gaps on both streams, a long result
// stall and a gap-free stretch. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import bsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 256;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;
    localparam int QUIET_LIMIT = 4000;

    // The fourth request kind, which the block answers with ok and no change.
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] slot_index
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] result_slot, [8] in_use,
                                 // [17:9] used_total, [23:18] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;

    int          answers_owed;
    int          mismatch_count;

    // Stimulus controls.
    bit          send_gaps;
    logic        rcv_gaps;
    logic        hold_toggle;
    logic        hold_seen;
    int          hold_left;
    int          gen_limit;
    int          quiet_cycles;

    always #5 clk = ~clk;

    bitmap_slot_allocator_unit #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    slot_result_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .answers_owed  (answers_owed),
        .mismatch_count(mismatch_count)
    );

    // Result side: random stalls, a long hold on request, or always ready.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_toggle != hold_seen)
        begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!rcv_gaps)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 37);
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request and wait until it is taken.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SLOT_W-1:0] idx);
        while (send_gaps && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= idx;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
    endtask

    // Stop offering and wait until every owed result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (answers_owed != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the slot count once the block is idle.
    task automatic set_slot_count(input logic [8:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        gen_limit    = (value > NUM_SLOTS) ? NUM_SLOTS : int'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Slot index mostly below the current limit, sometimes anywhere.
    function automatic logic [SLOT_W-1:0] pick_index();
        if (gen_limit == 0 || $urandom_range(99) < 25)
            return SLOT_W'($urandom_range(0, 255));
        return SLOT_W'($urandom_range(0, gen_limit - 1));
    endfunction

    // One random request with the given share of allocates.
    task automatic send_random(input int alloc_pct);
        int               r;
        int               rest;
        logic [REQ_W-1:0] kind;
        r    = $urandom_range(99);
        rest = 100 - alloc_pct;
        if (r < alloc_pct)
            kind = REQ_ALLOC;
        else if (r < alloc_pct + rest / 2)
            kind = REQ_FREE;
        else if (r < alloc_pct + (rest * 9) / 10)
            kind = REQ_QUERY;
        else
            kind = REQ_NONE;
        send_request(kind, pick_index());
    endtask

    // A random phase under one slot count; optionally with a long result stall.
    task automatic run_phase(input logic [8:0] value, input int count, input int alloc_pct,
                             input bit squeeze);
        set_slot_count(value);
        if (squeeze)
        begin
            // Gap-free requests against a stalled result side fill the block.
            hold_toggle <= ~hold_toggle;
            send_gaps    = 1'b0;
            repeat (40) send_random(alloc_pct);
            send_gaps    = 1'b1;
            count        = count - 40;
        end
        repeat (count) send_random(alloc_pct);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ALLOC;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_gaps     = 1'b1;
        rcv_gaps      = 1'b1;
        hold_toggle   = 1'b0;
        hold_seen     = 1'b0;
        hold_left     = 0;
        gen_limit     = NUM_SLOTS;
        quiet_cycles  = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: basic allocate, free and query on a fresh map.
        set_slot_count(9'd256);
        send_request(REQ_ALLOC, 8'hFF);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_ALLOC, 8'hA5);
        send_request(REQ_QUERY, 8'd1);
        send_request(REQ_QUERY, 8'd255);
        send_request(REQ_FREE, 8'd1);
        send_request(REQ_FREE, 8'd1);
        send_request(REQ_FREE, 8'd255);
        send_request(REQ_ALLOC, 8'h5A);
        send_request(REQ_NONE, 8'hFF);
        send_request(REQ_QUERY, 8'd0);

        // Directed: limit lowered below slots in use, which still count.
        set_slot_count(9'd2);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_FREE, 8'd2);
        send_request(REQ_QUERY, 8'd200);
        send_request(REQ_FREE, 8'd1);
        send_request(REQ_ALLOC, 8'h00);

        // Directed: a zero slot count refuses everything.
        set_slot_count(9'd0);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_QUERY, 8'd0);
        send_request(REQ_FREE, 8'd0);

        // Directed: back to full size, empty the map and allocate again.
        set_slot_count(9'd256);
        send_request(REQ_FREE, 8'd0);
        send_request(REQ_FREE, 8'd2);
        send_request(REQ_ALLOC, 8'h00);

        // Random phases over several slot counts.
        run_phase(9'd8, 80, 45, 1'b0);
        run_phase(9'd0, 30, 40, 1'b0);
        run_phase(9'd256, 360, 92, 1'b1);
        run_phase(9'd13, 100, 30, 1'b0);

        // A stretch with no idling on either side.
        send_gaps = 1'b0;
        rcv_gaps <= 1'b0;
        run_phase(9'd511, 120, 40, 1'b0);
        send_gaps = 1'b1;
        rcv_gaps <= 1'b1;

        run_phase(9'd1, 60, 45, 1'b0);
        run_phase(9'd100, 150, 35, 1'b0);
        run_phase(9'd256, 130, 40, 1'b0);

        drain();
        if (mismatch_count == 0 && answers_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
